// File: sv/srld_pkg.sv
`default_nettype none

package srld_pkg;

  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_DATA1   = 3'd1;
  localparam logic [2:0] PH_PAIR_A  = 3'd2;
  localparam logic [2:0] PH_PAIR_B  = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_STOPPED = 3'd5;

  localparam logic [1:0] EV_WRITE = 2'd0;
  localparam logic [1:0] EV_WAIT  = 2'd1;
  localparam logic [1:0] EV_LOOP  = 2'd2;
  localparam logic [1:0] EV_STOP  = 2'd3;

  localparam logic [7:0] OP_WAIT1  = 8'hFF;
  localparam logic [7:0] OP_LENGTH = 8'hFE;
  localparam logic [7:0] OP_END    = 8'hFD;
  localparam logic [7:0] OP_PAIR_V = 8'h1F;
  localparam logic [7:0] OP_PAIR_F = 8'h36;
  localparam logic [7:0] OP_PAIR_C = 8'h37;

  localparam logic [15:0] ADDR_V_A = 16'h9010;
  localparam logic [15:0] ADDR_V_B = 16'h9030;
  localparam logic [15:0] ADDR_F_A = 16'hF800;
  localparam logic [15:0] ADDR_F_B = 16'h4800;
  localparam logic [15:0] ADDR_C_A = 16'hC000;
  localparam logic [15:0] ADDR_C_B = 16'hE000;

  localparam logic [31:0] LENGTH_BIAS = 32'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [31:0] syncs;
  } event_t;

  function automatic logic [15:0] single_address(input logic [7:0] op);
    logic [15:0] addr;
    begin
      case (op) inside
        [8'h00:8'h15], [8'h40:8'h8F]: addr = 16'h4000 + {8'h00, op};
        [8'h16:8'h18]: addr = 16'h9000 + {8'h00, op - 8'h16};
        [8'h19:8'h1B]: addr = 16'hA000 + {8'h00, op - 8'h19};
        [8'h1C:8'h1E]: addr = 16'hB000 + {8'h00, op - 8'h1C};
        [8'h20:8'h35]: addr = 16'h5000 + {8'h00, op - 8'h20};
        default:       addr = 16'h5FF0 + {12'h000, op[3:0]};
      endcase
      return addr;
    end
  endfunction

  function automatic logic [15:0] pair_address(input logic [7:0] op, input logic second);
    logic [15:0] addr;
    begin
      case (op)
        OP_PAIR_V: addr = second ? ADDR_V_B : ADDR_V_A;
        OP_PAIR_F: addr = second ? ADDR_F_B : ADDR_F_A;
        default:   addr = second ? ADDR_C_B : ADDR_C_A;
      endcase
      return addr;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/srld_parser.sv
`default_nettype none

module srld_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      log_byte,
  input  wire logic            loop_enabled,
  output srld_pkg::event_t     result,
  output logic                 emit
);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [7:0]  held_opcode;
  logic [7:0]  held_opcode_next;
  logic [31:0] length_acc;
  logic [31:0] length_acc_next;
  logic [31:0] length_shift;

  assign length_shift = {length_acc[24:0], log_byte[6:0]};

  always_comb begin
    phase_next       = phase;
    held_opcode_next = held_opcode;
    length_acc_next  = length_acc;
    emit             = 1'b0;
    result           = '0;
    case (phase)
      srld_pkg::PH_STOPPED: begin
        emit = 1'b0;
      end
      srld_pkg::PH_DATA1: begin
        phase_next     = srld_pkg::PH_OPCODE;
        emit           = 1'b1;
        result.kind    = srld_pkg::EV_WRITE;
        result.address = srld_pkg::single_address(held_opcode);
        result.data    = log_byte;
      end
      srld_pkg::PH_PAIR_A: begin
        phase_next     = srld_pkg::PH_PAIR_B;
        emit           = 1'b1;
        result.kind    = srld_pkg::EV_WRITE;
        result.address = srld_pkg::pair_address(held_opcode, 1'b0);
        result.data    = log_byte;
      end
      srld_pkg::PH_PAIR_B: begin
        phase_next     = srld_pkg::PH_OPCODE;
        emit           = 1'b1;
        result.kind    = srld_pkg::EV_WRITE;
        result.address = srld_pkg::pair_address(held_opcode, 1'b1);
        result.data    = log_byte;
      end
      srld_pkg::PH_LENGTH: begin
        length_acc_next = length_shift;
        if (!log_byte[7]) begin
          phase_next   = srld_pkg::PH_OPCODE;
          emit         = 1'b1;
          result.kind  = srld_pkg::EV_WAIT;
          result.syncs = length_shift + srld_pkg::LENGTH_BIAS;
        end
      end
      default: begin
        phase_next       = srld_pkg::PH_OPCODE;
        held_opcode_next = log_byte;
        case (log_byte) inside
          srld_pkg::OP_WAIT1: begin
            emit         = 1'b1;
            result.kind  = srld_pkg::EV_WAIT;
            result.syncs = 32'd1;
          end
          srld_pkg::OP_LENGTH: begin
            length_acc_next = '0;
            phase_next      = srld_pkg::PH_LENGTH;
          end
          srld_pkg::OP_END: begin
            emit = 1'b1;
            if (loop_enabled) begin
              result.kind = srld_pkg::EV_LOOP;
            end else begin
              result.kind = srld_pkg::EV_STOP;
              phase_next  = srld_pkg::PH_STOPPED;
            end
          end
          srld_pkg::OP_PAIR_V, srld_pkg::OP_PAIR_F, srld_pkg::OP_PAIR_C: begin
            phase_next = srld_pkg::PH_PAIR_A;
          end
          [8'h00:8'h1E], [8'h20:8'h35], [8'h3C:8'h8F]: begin
            phase_next = srld_pkg::PH_DATA1;
          end
          default: begin
            phase_next = srld_pkg::PH_OPCODE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= srld_pkg::PH_OPCODE;
      held_opcode <= '0;
      length_acc  <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      held_opcode <= held_opcode_next;
      length_acc  <= length_acc_next;
    end
  end

  // once stopped, only reset leaves the stopped phase
  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == srld_pkg::PH_STOPPED |=> phase == srld_pkg::PH_STOPPED)
    else $error("stopped phase left without reset");

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    phase == srld_pkg::PH_STOPPED |-> !emit)
    else $error("event produced while stopped");

  a_stop_enters: assert property (@(posedge clk) disable iff (rst)
    fire && emit && result.kind == srld_pkg::EV_STOP |=> phase == srld_pkg::PH_STOPPED)
    else $error("stop event without stopped phase");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    fire && phase == srld_pkg::PH_PAIR_A |=> phase == srld_pkg::PH_PAIR_B)
    else $error("second data byte of pair skipped");

endmodule

`default_nettype wire

// File: sv/srld_out_stage.sv
`default_nettype none

module srld_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic              emit,
  input  wire srld_pkg::event_t  result,
  input  wire logic              out_stall,
  output logic                   advance,
  output logic                   out_valid,
  output logic [1:0]             event_kind,
  output logic [15:0]            reg_address,
  output logic [7:0]             reg_data,
  output logic [31:0]            wait_syncs
);

  srld_pkg::event_t held;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && emit) begin
      held <= result;
    end
  end

  assign event_kind  = held.kind;
  assign reg_address = held.address;
  assign reg_data    = held.data;
  assign wait_syncs  = held.syncs;

endmodule

`default_nettype wire

// File: sv/sound_register_log_decoder_top.sv
// result path: an accepted byte is held in the input register, parsed, and
// its result word, if it makes one, is registered in the output stage
// throughput: one log byte per cycle while the output is not stalled, set by
// the single parse step between the input register and the result register
// reset: synchronous, clears the parser to opcode phase, drops both valid flags
// and clears loop_enabled to 0
`default_nettype none

module sound_register_log_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  log_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_kind,
  output logic [15:0]      reg_address,
  output logic [7:0]       reg_data,
  output logic [31:0]      wait_syncs,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             loop_enabled;
  logic             in_q_valid;
  logic [7:0]       in_q_byte;
  logic             advance;
  logic             fire;
  logic             emit;
  srld_pkg::event_t result;

  // config register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, loop_enabled};

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enabled <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      loop_enabled <= pwdata[0];
    end
  end

  // input register
  assign in_stall = in_q_valid && !advance;
  assign fire     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= log_byte;
    end
  end

  srld_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .log_byte     (in_q_byte),
    .loop_enabled (loop_enabled),
    .result       (result),
    .emit         (emit)
  );

  srld_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .emit        (emit),
    .result      (result),
    .out_stall   (out_stall),
    .advance     (advance),
    .out_valid   (out_valid),
    .event_kind  (event_kind),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .wait_syncs  (wait_syncs)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] LOOP_ENABLED_ADDR = 3'd0;
  localparam int IDLE_LIMIT = 2000;

  class event_scoreboard;
    logic        loop_on;
    logic [2:0]  phase;
    logic [7:0]  opcode;
    logic [31:0] length_acc;
    srld_pkg::event_t expected_events[$];
    int          errors;

    function new();
      loop_on = 1'b0;
      phase = srld_pkg::PH_OPCODE;
      opcode = 8'h00;
      length_acc = 32'd0;
      errors = 0;
    endfunction

    static function int operand_count(logic [7:0] b);
      if (b == srld_pkg::OP_PAIR_V || b == srld_pkg::OP_PAIR_F ||
          b == srld_pkg::OP_PAIR_C) return 2;
      if (b <= 8'h1E || (b >= 8'h20 && b <= 8'h35) || (b >= 8'h3C && b <= 8'h8F)) return 1;
      return 0;
    endfunction

    function logic [15:0] chip_address(logic [7:0] op, bit second);
      int k, ch;
      if (operand_count(op) == 2) begin
        case (op)
          srld_pkg::OP_PAIR_V: return second ? srld_pkg::ADDR_V_B : srld_pkg::ADDR_V_A;
          srld_pkg::OP_PAIR_F: return second ? srld_pkg::ADDR_F_B : srld_pkg::ADDR_F_A;
          default:             return second ? srld_pkg::ADDR_C_B : srld_pkg::ADDR_C_A;
        endcase
      end
      if (op <= 8'h15 || (op >= 8'h40 && op <= 8'h8F)) return 16'h4000 + 16'(op);
      if (op >= 8'h16 && op <= 8'h1E) begin
        k = int'(op) - 'h16;
        ch = k / 3;
        return 16'(32'h9000 + 32'h1000 * ch + (k - 3 * ch));
      end
      if (op >= 8'h20 && op <= 8'h35) return 16'h5000 + 16'(op - 8'h20);
      return 16'h5FF0 + 16'(op[3:0]);
    endfunction

    // predicts the event, if any, caused by one accepted log word
    function void note_byte(logic [7:0] b);
      srld_pkg::event_t ev;
      bit     emit;
      ev = '0;
      emit = 1'b0;
      case (phase)
        srld_pkg::PH_STOPPED: ;
        srld_pkg::PH_DATA1: begin
          phase = srld_pkg::PH_OPCODE;
          ev.kind = srld_pkg::EV_WRITE;
          ev.address = chip_address(opcode, 1'b0);
          ev.data = b;
          emit = 1'b1;
        end
        srld_pkg::PH_PAIR_A: begin
          phase = srld_pkg::PH_PAIR_B;
          ev.kind = srld_pkg::EV_WRITE;
          ev.address = chip_address(opcode, 1'b0);
          ev.data = b;
          emit = 1'b1;
        end
        srld_pkg::PH_PAIR_B: begin
          phase = srld_pkg::PH_OPCODE;
          ev.kind = srld_pkg::EV_WRITE;
          ev.address = chip_address(opcode, 1'b1);
          ev.data = b;
          emit = 1'b1;
        end
        srld_pkg::PH_LENGTH: begin
          length_acc = {length_acc[24:0], b[6:0]};
          if (!b[7]) begin
            phase = srld_pkg::PH_OPCODE;
            ev.kind = srld_pkg::EV_WAIT;
            ev.syncs = length_acc + srld_pkg::LENGTH_BIAS;
            emit = 1'b1;
          end
        end
        default: begin
          phase = srld_pkg::PH_OPCODE;
          opcode = b;
          if (b == srld_pkg::OP_WAIT1) begin
            ev.kind = srld_pkg::EV_WAIT;
            ev.syncs = 32'd1;
            emit = 1'b1;
          end else if (b == srld_pkg::OP_LENGTH) begin
            length_acc = 32'd0;
            phase = srld_pkg::PH_LENGTH;
          end else if (b == srld_pkg::OP_END) begin
            if (loop_on) begin
              ev.kind = srld_pkg::EV_LOOP;
            end else begin
              ev.kind = srld_pkg::EV_STOP;
              phase = srld_pkg::PH_STOPPED;
            end
            emit = 1'b1;
          end else if (operand_count(b) == 2) begin
            phase = srld_pkg::PH_PAIR_A;
          end else if (operand_count(b) == 1) begin
            phase = srld_pkg::PH_DATA1;
          end
        end
      endcase
      if (emit) expected_events.push_back(ev);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] %s", $time, msg);
    endtask

    task check_event(srld_pkg::event_t got);
      srld_pkg::event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d addr %h data %h syncs %0d",
                         got.kind, got.address, got.data, got.syncs));
      end else begin
        want = expected_events.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("event_kind %0d, wanted %0d", got.kind, want.kind));
        if (got.address !== want.address)
          report($sformatf("reg_address %h, wanted %h", got.address, want.address));
        if (got.data !== want.data)
          report($sformatf("reg_data %h, wanted %h", got.data, want.data));
        if (got.syncs !== want.syncs)
          report($sformatf("wait_syncs %0d, wanted %0d", got.syncs, want.syncs));
      end
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  log_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  event_kind;
  logic [15:0] reg_address;
  logic [7:0]  reg_data;
  logic [31:0] wait_syncs;
  logic [31:0] prdata;
  logic        pready;

  event_scoreboard sb = new();
  logic [7:0]  log_feed[$];
  srld_pkg::event_t got_event;
  int          events_seen = 0;
  int          hold_left = 0;
  int          pattern_left = 0;
  int          stall_pct = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  sound_register_log_decoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .log_byte(log_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .reg_address(reg_address),
    .reg_data(reg_data), .wait_syncs(wait_syncs),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // result side: check, then choose the stall for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_event.kind = event_kind;
        got_event.address = reg_address;
        got_event.data = reg_data;
        got_event.syncs = wait_syncs;
        sb.check_event(got_event);
        events_seen++;
        if (events_seen % 300 == 60) hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          pattern_left = $urandom_range(20, 80);
        end
        pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one command with random operands; the end marker only where allowed
  task add_command(bit end_ok);
    logic [7:0] op;
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      op = srld_pkg::OP_WAIT1;
    end else if (r < 18) begin
      op = srld_pkg::OP_LENGTH;
    end else if (r < 23) begin
      op = end_ok ? srld_pkg::OP_END : srld_pkg::OP_WAIT1;
    end else if (r < 33) begin
      case ($urandom_range(0, 2))
        0: op = srld_pkg::OP_PAIR_V;
        1: op = srld_pkg::OP_PAIR_F;
        default: op = srld_pkg::OP_PAIR_C;
      endcase
    end else if (r < 82) begin
      do op = 8'($urandom_range(0, 'h8F)); while (event_scoreboard::operand_count(op) != 1);
    end else begin
      do op = 8'($urandom_range(0, 255)); while (op == srld_pkg::OP_END && !end_ok);
    end
    log_feed.push_back(op);
    if (op == srld_pkg::OP_LENGTH) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      repeat (n - 1) log_feed.push_back({1'b1, 7'($urandom)});
      log_feed.push_back({1'b0, 7'($urandom)});
    end else begin
      repeat (event_scoreboard::operand_count(op)) log_feed.push_back(8'($urandom));
    end
  endtask

  task feed_log();
    while (log_feed.size() != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      log_byte <= log_feed[0];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_byte(log_feed.pop_front());
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  task settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task program_loop(logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LOOP_ENABLED_ADDR;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.loop_on = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task random_phase(logic v, int count);
    settle();
    program_loop(v);
    while (log_feed.size() < count) add_command(v);
    feed_log();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_loop(1'b1);
    // range ends, pairs, waits, skipped opcodes, loop marker, wrapping length
    log_feed = '{8'h00, 8'hAA, 8'h8F, 8'h55, 8'h1E, 8'h7F, 8'h3F, 8'h80,
                 srld_pkg::OP_PAIR_V, 8'h11, 8'h22, srld_pkg::OP_PAIR_C, 8'h00, 8'hFF,
                 srld_pkg::OP_WAIT1, srld_pkg::OP_LENGTH, 8'h00, 8'h38, 8'hFC,
                 srld_pkg::OP_END,
                 srld_pkg::OP_LENGTH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    feed_log();
    random_phase(1'b1, 150);
    random_phase(1'b0, 200);
    random_phase(1'b1, 200);
    random_phase(1'b0, 100);
    // end marker with looping off stops the decoder; later words are ignored
    log_feed.push_back(srld_pkg::OP_END);
    repeat (12) log_feed.push_back(8'($urandom));
    log_feed.push_back(srld_pkg::OP_WAIT1);
    feed_log();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
sv/srld_pkg.sv
sv/srld_parser.sv
sv/srld_out_stage.sv
sv/sound_register_log_decoder_top.sv
bench/tb_top.sv
